// ===== rtl/core/fcbl_pkg.sv =====
// Package for the count- and byte-limited FIFO cache.
// Holds the store depth, derived widths, payload structs and register indexes.
// No dependencies.
package fcbl_pkg;

  localparam int DEPTH   = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int LIM_W   = (CNT_W > 6) ? CNT_W : 6;
  localparam int BYTES_W = 32 + CNT_W;

  localparam logic [0:0] REG_MAX_ENTRIES = 1'b0;
  localparam logic [0:0] REG_MAX_BYTES   = 1'b1;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] item_bytes;
  } item_t;

  typedef struct packed {
    logic        evicted_valid;
    logic [31:0] evicted_key;
    logic        last;
  } result_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// ===== rtl/core/fifo_cache_count_byte_limited_top.sv =====
// Top level of the count- and byte-limited FIFO cache: control, limits, counters.
// Depends on fcbl_pkg and fcbl_chain.
//
//   channel   handshake           payload
//   input     start / busy        item   (key, item_bytes)
//   result    done (strobe)       result (evicted_valid, evicted_key, last)
//   config    cfg_we              cfg_index, cfg_data
//
// An item with no eviction passes the insert, then one limit check.
// Each eviction adds one more limit check, and an insert into a full store a
// pop first; the cell chain pops one item per cycle from its oldest end.
// Each result is registered and leaves in the cycle after the check that decides its last flag.
// Reset empties the store and sets max_entries to 32 and max_bytes to all ones.
// Results cannot be stalled; busy drops in the cycle that carries the last one.
module fifo_cache_count_byte_limited_top
  import fcbl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output result_t     result
);

  typedef enum logic [1:0] {
    IDLE,
    INSERT,
    EVICT
  } state_t;

  state_t             state;
  logic [5:0]         max_entries;
  logic [31:0]        max_bytes;
  logic [CNT_W-1:0]   count;
  logic [BYTES_W-1:0] bytes;
  item_t              pend;
  logic               held_v;
  logic [31:0]        held_key;

  logic [LIM_W-1:0]   limit;
  logic               accept;
  logic               full;
  logic               need;
  logic               shift;
  logic               load;
  item_t              new_entry;
  item_t              oldest;

  assign busy   = (state != IDLE);
  assign accept = start && (state == IDLE);
  assign full   = (count == CNT_W'(DEPTH));
  assign limit  = (LIM_W'(max_entries) > LIM_W'(DEPTH)) ? LIM_W'(DEPTH)
                                                         : LIM_W'(max_entries);
  assign need   = (count != '0) &&
                  ((LIM_W'(count) > limit) || (bytes > BYTES_W'(max_bytes)));

  // Chain control: pop on a full insert or an eviction, load at the tail.
  assign shift     = (accept && full) || (state == EVICT && need);
  assign load      = (accept && !full) || (state == INSERT);
  assign new_entry = (state == INSERT) ? pend : item;

  fcbl_chain u_chain (
    .clk       (clk),
    .shift     (shift),
    .load      (load),
    .load_sel  (count),
    .new_entry (new_entry),
    .oldest    (oldest)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= 6'd32;
      max_bytes   <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_ENTRIES: max_entries <= cfg_data[5:0];
        REG_MAX_BYTES:   max_bytes   <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      count  <= '0;
      bytes  <= '0;
      held_v <= 1'b0;
      done   <= 1'b0;
      result <= '0;
    end else begin
      case (state)
        IDLE: begin
          done <= 1'b0;
          if (accept) begin
            if (full) begin
              // store full: pop the oldest first, insert next cycle
              pend     <= item;
              held_key <= oldest.key;
              held_v   <= 1'b1;
              count    <= count - CNT_W'(1);
              bytes    <= bytes - BYTES_W'(oldest.item_bytes);
              state    <= INSERT;
            end else begin
              held_v <= 1'b0;
              count  <= count + CNT_W'(1);
              bytes  <= bytes + BYTES_W'(item.item_bytes);
              state  <= EVICT;
            end
          end
        end
        INSERT: begin
          done  <= 1'b0;
          count <= count + CNT_W'(1);
          bytes <= bytes + BYTES_W'(pend.item_bytes);
          state <= EVICT;
        end
        EVICT: begin
          if (need) begin
            // hold this key until we know whether another pop follows
            done <= held_v;
            if (held_v) begin
              result.evicted_valid <= 1'b1;
              result.evicted_key   <= held_key;
              result.last          <= 1'b0;
            end
            held_key <= oldest.key;
            held_v   <= 1'b1;
            count    <= count - CNT_W'(1);
            bytes    <= bytes - BYTES_W'(oldest.item_bytes);
          end else begin
            done                 <= 1'b1;
            result.evicted_valid <= held_v;
            result.evicted_key   <= held_v ? held_key : 32'd0;
            result.last          <= 1'b1;
            held_v               <= 1'b0;
            state                <= IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/fcbl_cell.sv =====
// One storage cell of the FIFO chain: holds a key and its byte size.
// Loads a new item or takes its newer neighbor's item on a shift.
// Depends on fcbl_pkg.
module fcbl_cell
  import fcbl_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  item_t     new_entry,
  input  item_t     next_entry,
  output item_t     entry
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= new_entry;
    end else if (ctl.shift) begin
      entry <= next_entry;
    end
  end

endmodule

// ===== rtl/core/fcbl_chain.sv =====
// Row of DEPTH cells, oldest item in cell 0, newest at cell count-1.
// A shift moves every item one cell toward the oldest end.
// Depends on fcbl_pkg and fcbl_cell.
module fcbl_chain
  import fcbl_pkg::*;
(
  input  logic             clk,
  input  logic             shift,
  input  logic             load,
  input  logic [CNT_W-1:0] load_sel,
  input  item_t            new_entry,
  output item_t            oldest
);

  item_t entries [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    item_t     next_entry;

    assign ctl.shift = shift;
    assign ctl.load  = load && (load_sel == CNT_W'(i));

    if (i == DEPTH - 1) begin : g_tail
      assign next_entry = entries[i];
    end else begin : g_mid
      assign next_entry = entries[i + 1];
    end

    fcbl_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_entry  (new_entry),
      .next_entry (next_entry),
      .entry      (entries[i])
    );
  end

  assign oldest = entries[0];

endmodule

// ===== tb/tb_fifo_cache_count_byte_limited_top.sv =====
// Self-checking testbench for fifo_cache_count_byte_limited_top: keeps its own copy
// of the FIFO cache and both limit registers, predicts the evicted keys of each insert.
// Depends on fcbl_pkg and the RTL of the cache.
module tb_fifo_cache_count_byte_limited_top;
  import fcbl_pkg::*;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  item_t       item_in;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        done;
  result_t     result;

  // Predicted cache contents and limits
  logic [31:0]        cache_keys[$];
  logic [31:0]        cache_sizes[$];
  logic [BYTES_W-1:0] cache_bytes;
  logic [5:0]         lim_entries;
  logic [31:0]        lim_bytes;

  result_t     expected_evictions[$];
  int          inserts_sent;
  int          results_seen;
  int          evictions_predicted;
  int          fail_count;
  bit          sender_bursty;

  fifo_cache_count_byte_limited_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item_in),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(12 * 400000);
    $display("Verification failed");
    $finish;
  end

  function automatic logic [31:0] pop_oldest();
    logic [31:0] k;
    k = cache_keys.pop_front();
    cache_bytes = cache_bytes - {{(BYTES_W-32){1'b0}}, cache_sizes.pop_front()};
    return k;
  endfunction

  // Insert one item into the predicted cache and queue the results it causes
  function automatic void predict_insert(input item_t it);
    logic [31:0] evicted[$];
    int          cap;
    result_t     r;
    cap = (lim_entries > DEPTH) ? DEPTH : int'(lim_entries);
    if (cache_keys.size() >= DEPTH)
      evicted.push_back(pop_oldest());
    cache_keys.push_back(it.key);
    cache_sizes.push_back(it.item_bytes);
    cache_bytes = cache_bytes + {{(BYTES_W-32){1'b0}}, it.item_bytes};
    while (cache_keys.size() > 0 &&
           (cache_keys.size() > cap || cache_bytes > {{(BYTES_W-32){1'b0}}, lim_bytes}))
      evicted.push_back(pop_oldest());
    if (evicted.size() == 0) begin
      r.evicted_valid = 1'b0;
      r.evicted_key   = 32'd0;
      r.last          = 1'b1;
      expected_evictions.push_back(r);
    end else begin
      foreach (evicted[i]) begin
        r.evicted_valid = 1'b1;
        r.evicted_key   = evicted[i];
        r.last          = (i == evicted.size() - 1);
        expected_evictions.push_back(r);
      end
    end
    evictions_predicted += evicted.size();
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && done === 1'b1) begin
      results_seen++;
      if (expected_evictions.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: valid=%0b key=%h last=%0b",
                   result.evicted_valid, result.evicted_key, result.last);
      end else begin
        want = expected_evictions.pop_front();
        if (result.evicted_valid !== want.evicted_valid ||
            result.evicted_key !== want.evicted_key || result.last !== want.last) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"result %0d mismatch: expected valid=%0b key=%h last=%0b,",
                      " got valid=%0b key=%h last=%0b"},
                     results_seen, want.evicted_valid, want.evicted_key, want.last,
                     result.evicted_valid, result.evicted_key, result.last);
        end
      end
    end
  end

  // Send one item after a gap of idle cycles; start stays high after acceptance
  task automatic send_item(input logic [31:0] k, input logic [31:0] sz, input int gap);
    item_t it;
    it.key        = k;
    it.item_bytes = sz;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    item_in <= it;
    do @(posedge clk); while (busy);
    predict_insert(it);
    inserts_sent++;
  endtask

  // Hold off until every expected result is out and the block is idle
  task automatic wait_until_idle();
    start <= 1'b0;
    while (expected_evictions.size() != 0 || busy !== 1'b0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_ENTRIES)
      lim_entries = data[5:0];
    else
      lim_bytes = data;
    @(posedge clk);
  endtask

  function automatic int draw_gap();
    return sender_bursty ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic test_boundary_values();
    send_item(32'h0000_0000, 32'h0000_0000, 0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_item(32'h0000_0001, 32'h0000_0001, 0);
    send_item(32'h5555_5555, 32'h5555_5555, 0);
    send_item(32'hAAAA_AAAA, 32'hAAAA_AAAA, 0);
  endtask

  task automatic test_entry_limit_zero();
    wait_until_idle();
    // upper data bits must be dropped by the 6-bit register
    write_reg(REG_MAX_ENTRIES, 32'hFFFF_FFC0);
    send_item(32'h1234_5678, 32'd10, 0);
    send_item(32'h8765_4321, 32'd0, 3);
    wait_until_idle();
    write_reg(REG_MAX_ENTRIES, 32'h0000_0001);
    send_item(32'h0000_0011, 32'd5, 0);
    send_item(32'h0000_0022, 32'd6, 0);
    send_item(32'h0000_0033, 32'd7, 1);
  endtask

  task automatic test_oversize_item();
    wait_until_idle();
    write_reg(REG_MAX_ENTRIES, 32'd32);
    write_reg(REG_MAX_BYTES, 32'd100);
    send_item(32'hC0DE_0001, 32'd40, 0);
    send_item(32'hC0DE_0002, 32'd50, 0);
    send_item(32'hC0DE_0003, 32'd101, 2);
    send_item(32'hC0DE_0004, 32'd100, 0);
    send_item(32'hC0DE_0005, 32'd0, 0);
    wait_until_idle();
    write_reg(REG_MAX_BYTES, 32'd0);
    send_item(32'hC0DE_0006, 32'd0, 0);
    send_item(32'hC0DE_0007, 32'd0, 0);
    send_item(32'hC0DE_0008, 32'd1, 0);
  endtask

  // Overflow the store, then drop the entry limit so one insert flushes everything
  task automatic test_full_store_and_drop();
    wait_until_idle();
    write_reg(REG_MAX_ENTRIES, 32'd63);
    write_reg(REG_MAX_BYTES, 32'hFFFF_FFFF);
    sender_bursty = 1'b0;
    for (int i = 0; i < DEPTH + 2; i++)
      send_item($urandom, $urandom_range(0, 1000), draw_gap());
    wait_until_idle();
    write_reg(REG_MAX_ENTRIES, 32'd0);
    send_item($urandom, $urandom_range(0, 1000), 0);
    wait_until_idle();
    write_reg(REG_MAX_ENTRIES, 32'd32);
    for (int i = 0; i < DEPTH; i++)
      send_item($urandom, 32'd1, 0);
    wait_until_idle();
    write_reg(REG_MAX_ENTRIES, 32'd1);
    send_item($urandom, 32'd1, 0);
  endtask

  task automatic run_limit_phase(input logic [5:0] entries, input logic [31:0] byte_limit,
                                 input logic [31:0] size_cap, input int n_items);
    logic [31:0] sz;
    wait_until_idle();
    write_reg(REG_MAX_ENTRIES, ($urandom & 32'hFFFF_FFC0) | {26'd0, entries});
    write_reg(REG_MAX_BYTES, byte_limit);
    sender_bursty = ($urandom_range(0, 2) == 0);
    for (int i = 0; i < n_items; i++) begin
      // pause now and then until the block has drained
      if ($urandom_range(0, 29) == 0)
        wait_until_idle();
      sz = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, size_cap);
      send_item($urandom, sz, draw_gap());
    end
  endtask

  task automatic test_random_traffic();
    run_limit_phase(6'd32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 14);
    run_limit_phase(6'd63, 32'hFFFF_FFFF, $urandom_range(0, 50000), 14);
    run_limit_phase(6'($urandom_range(1, 6)), 32'hFFFF_FFFF, 32'd1000, 14);
    run_limit_phase(6'($urandom_range(0, 63)), 32'd5000, 32'd1500, 14);
    run_limit_phase(6'($urandom_range(0, 63)), $urandom_range(0, 300), 32'd120, 14);
    run_limit_phase(6'd1, 32'd0, 32'd3, 14);
    run_limit_phase(6'($urandom_range(0, 63)), $urandom, $urandom, 14);
    run_limit_phase(6'd32, 32'd20000, 32'd2000, 14);
  endtask

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    item_in   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_MAX_ENTRIES;
    cfg_data  <= 32'd0;
    cache_bytes         = '0;
    lim_entries         = 6'd32;
    lim_bytes           = 32'hFFFF_FFFF;
    inserts_sent        = 0;
    results_seen        = 0;
    evictions_predicted = 0;
    fail_count          = 0;
    sender_bursty       = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_boundary_values();
    test_entry_limit_zero();
    test_oversize_item();
    test_full_store_and_drop();
    test_random_traffic();

    wait_until_idle();
    repeat (20) @(posedge clk);

    $display("Covered %0d inserts and %0d results (%0d evictions): reset limits, zero and",
             inserts_sent, results_seen, evictions_predicted);
    $display("single-entry limits, oversize items, full-store flushes and random limit phases.");
    if (fail_count == 0 && expected_evictions.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results still expected", fail_count,
               expected_evictions.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== fifo_cache_count_byte_limited_top.f =====
rtl/core/fcbl_pkg.sv
rtl/core/fcbl_cell.sv
rtl/core/fcbl_chain.sv
rtl/core/fifo_cache_count_byte_limited_top.sv
tb/tb_fifo_cache_count_byte_limited_top.sv
